@@ rtl/mbe_pkg.sv @@
// mbe_pkg: shared types, constants and helpers of the escape-time block
// transaction payloads, controller/datapath command and status, saturation
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

	localparam int FRAC_BITS  = 28;
	localparam int MAG_SHIFT  = 2 * FRAC_BITS + 2;
	localparam bit CAN_ESCAPE = (MAG_SHIFT < 64);
	localparam logic [63:0] MAG_LIMIT = CAN_ESCAPE ? (64'd1 << MAG_SHIFT) : 64'd0;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_LEFT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_TOP    = 2'd3;

	localparam logic signed [31:0] RST_LEFT   = -32'sd536870912;
	localparam logic signed [31:0] RST_RIGHT  = 32'sd268435456;
	localparam logic signed [31:0] RST_BOTTOM = -32'sd402653184;
	localparam logic signed [31:0] RST_TOP    = 32'sd402653184;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [15:0] coord_u;
		logic [15:0] coord_v;
	} in_item_t;

	typedef struct packed {
		logic [8:0] iter_count;
		logic [8:0] shade;
		logic       inside_res;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic map_mul;
		logic map_add;
		logic iter_mul;
		logic iter_upd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic limit_hit;
		logic escaped;
	} status_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
		logic signed [31:0] r;
		if (a > SAT_MAX) begin
			r = 32'sh7fffffff;
		end else if (a < SAT_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = a[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/mbe_datapath.sv @@
// mbe_datapath: window registers, coordinate mapping and z = z^2 + c iteration
// driven by mbe_ctrl through cmd_t, reports status_t; uses mbe_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbe_datapath import mbe_pkg::*; #(
	parameter int unsigned MAX_ITER = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire in_item_t             in_data,
	input  wire cmd_t                 cmd,
	output status_t                   status,
	output out_item_t                 out_data
);

	localparam int CNT_W = $clog2(MAX_ITER + 1);

	logic signed [31:0] win_left_q, win_right_q, win_bottom_q, win_top_q;
	logic [15:0]        u_q, v_q;
	logic signed [49:0] prodx_q, prody_q;
	logic signed [31:0] cx_q, cy_q, x_q, y_q;
	logic signed [63:0] xx_q, yy_q, xy_q;
	logic [CNT_W-1:0]   count_q;
	out_item_t          out_q;

	logic signed [32:0] span_x, span_y;
	logic signed [49:0] prodx_d, prody_d;
	logic signed [63:0] mapx_sum, mapy_sum;
	logic signed [63:0] xx_d, yy_d, xy_d;
	logic [63:0]        mag;
	logic signed [63:0] diff, xn_sum, yn_sum;
	logic [CNT_W+8:0]   cnt_ext, shade_ext;
	logic [CNT_W-1:0]   shade_full;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= RST_LEFT;
			win_right_q  <= RST_RIGHT;
			win_bottom_q <= RST_BOTTOM;
			win_top_q    <= RST_TOP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEFT:   win_left_q   <= cfg_data;
				REG_RIGHT:  win_right_q  <= cfg_data;
				REG_BOTTOM: win_bottom_q <= cfg_data;
				REG_TOP:    win_top_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// mapping into the window
	assign span_x  = $signed({win_right_q[31], win_right_q}) - $signed({win_left_q[31], win_left_q});
	assign span_y  = $signed({win_top_q[31], win_top_q}) - $signed({win_bottom_q[31], win_bottom_q});
	assign prodx_d = $signed({1'b0, u_q}) * span_x;
	assign prody_d = $signed({1'b0, v_q}) * span_y;

	assign mapx_sum = $signed({{30{prodx_q[49]}}, prodx_q[49:16]})
		+ $signed({{32{win_left_q[31]}}, win_left_q});
	assign mapy_sum = $signed({{30{prody_q[49]}}, prody_q[49:16]})
		+ $signed({{32{win_bottom_q[31]}}, win_bottom_q});

	// iteration
	assign xx_d = x_q * x_q;
	assign yy_d = y_q * y_q;
	assign xy_d = x_q * y_q;

	assign mag    = xx_q + yy_q;
	assign diff   = xx_q - yy_q;
	assign xn_sum = (diff >>> FRAC_BITS) + $signed({{32{cx_q[31]}}, cx_q});
	assign yn_sum = (xy_q >>> (FRAC_BITS - 1)) + $signed({{32{cy_q[31]}}, cy_q});

	assign status.limit_hit = (count_q >= CNT_W'(MAX_ITER));
	assign status.escaped   = CAN_ESCAPE && (mag > MAG_LIMIT);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			u_q <= in_data.coord_u;
			v_q <= in_data.coord_v;
		end
		if (cmd.map_mul) begin
			prodx_q <= prodx_d;
			prody_q <= prody_d;
		end
		if (cmd.map_add) begin
			cx_q    <= sat32(mapx_sum);
			cy_q    <= sat32(mapy_sum);
			x_q     <= sat32(mapx_sum);
			y_q     <= sat32(mapy_sum);
			count_q <= '0;
		end
		if (cmd.iter_mul) begin
			xx_q <= xx_d;
			yy_q <= yy_d;
			xy_q <= xy_d;
		end
		if (cmd.iter_upd) begin
			x_q     <= sat32(xn_sum);
			y_q     <= sat32(yn_sum);
			count_q <= count_q + CNT_W'(1);
		end
		if (cmd.load_out) begin
			out_q.iter_count <= cnt_ext[8:0];
			out_q.shade      <= shade_ext[8:0];
			out_q.inside_res <= status.limit_hit;
		end
	end

	// result fields, masked to nine bits
	assign shade_full = CNT_W'(MAX_ITER) - count_q;
	assign cnt_ext    = {9'd0, count_q};
	assign shade_ext  = {9'd0, shade_full};

	assign out_data = out_q;

endmodule

`default_nettype wire

@@ rtl/mbe_ctrl.sv @@
// mbe_ctrl: sequencing state machine and output valid for the escape-time block
// commands mbe_datapath through cmd_t, reads status_t; uses mbe_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbe_ctrl import mbe_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_MAP_MUL = 6'b000010,
		S_MAP_ADD = 6'b000100,
		S_IT_MUL  = 6'b001000,
		S_IT_UPD  = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_MAP_MUL;
				end
			end
			S_MAP_MUL: begin
				cmd.map_mul = 1'b1;
				state_d     = S_MAP_ADD;
			end
			S_MAP_ADD: begin
				cmd.map_add = 1'b1;
				state_d     = S_IT_MUL;
			end
			S_IT_MUL: begin
				if (status.limit_hit) begin
					state_d = S_DONE;
				end else begin
					cmd.iter_mul = 1'b1;
					state_d      = S_IT_UPD;
				end
			end
			S_IT_UPD: begin
				if (status.escaped) begin
					state_d = S_DONE;
				end else begin
					cmd.iter_upd = 1'b1;
					state_d      = S_IT_MUL;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/mandelbrot_escape_time.sv @@
// mandelbrot_escape_time: top level of the escape-time evaluator
// joins mbe_ctrl and mbe_datapath; uses mbe_pkg
//
// in_valid/in_ready carry one point (coord_u, coord_v, unsigned Q0.16) per
// transaction; out_valid/out_ready return one result (iter_count, shade,
// inside_res) per point, in order. cfg_we/cfg_index/cfg_data write the four
// Q4.28 window bounds (left, right, bottom, top); write only while idle.
// One point is in work at a time: the accept step, the mapping multiply and
// add steps, then per iteration a 32x32 product step and an update and escape
// test step. in_ready returns when the result is registered, together with
// out_valid.
// The result sits in an output register: a new point is accepted and worked
// on while the receiver stalls; a finished result waits until that register
// is free. Reset clears the controller and restores the default window.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; #(
	parameter int unsigned MAX_ITER = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_data,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	cmd_t    cmd;
	status_t status;

	mbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mbe_datapath #(
		.MAX_ITER (MAX_ITER)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

	// one point in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a point is in work");

	a_count_shade_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (9'(out_data.iter_count + out_data.shade) == 9'(MAX_ITER)))
		else $error("iter_count and shade do not add up to the limit");

	a_inside_shade: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (MAX_ITER < 512) |-> (out_data.inside_res == (out_data.shade == 9'd0)))
		else $error("inside flag disagrees with shade");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pending result dropped");

endmodule

`default_nettype wire

@@ sim/tb_mandelbrot_escape_time.sv @@
// tb_mandelbrot_escape_time: self-checking testbench of the escape-time evaluator
// drives points through valid/ready with random gaps, predicts each escape count
// itself and checks every result in order; depends on mbe_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;
	import mbe_pkg::*;

	localparam int unsigned MAX_ITER    = 256;
	localparam int          HOLD_CYCLES = 1500;
	localparam longint      Q_MAX       = 64'sd2147483647;
	localparam longint      Q_MIN       = -64'sd2147483648;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_LEFT;
	logic [31:0]          cfg_data  = '0;

	// window copy used for prediction
	longint win_left   = RST_LEFT;
	longint win_right  = RST_RIGHT;
	longint win_bottom = RST_BOTTOM;
	longint win_top    = RST_TOP;

	out_item_t expected_escapes[$];
	int        mismatches = 0;
	bit        hold_off   = 1'b0;
	bit        quiet      = 1'b0;

	mandelbrot_escape_time #(
		.MAX_ITER(MAX_ITER)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint clip32(input longint a);
		if (a > Q_MAX) begin
			return Q_MAX;
		end
		if (a < Q_MIN) begin
			return Q_MIN;
		end
		return a;
	endfunction

	function automatic longint map_to_plane(input logic [15:0] pos, input longint lo,
			input longint hi);
		longint prod;
		prod = longint'({48'd0, pos}) * (hi - lo);
		return clip32(lo + (prod >>> 16));
	endfunction

	function automatic out_item_t escape_time(input in_item_t pt);
		longint          cx, cy, x, y, xx, yy, xy;
		longint unsigned mag;
		int unsigned     n;
		out_item_t       r;
		cx = map_to_plane(pt.coord_u, win_left, win_right);
		cy = map_to_plane(pt.coord_v, win_bottom, win_top);
		x = cx;
		y = cy;
		n = 0;
		// limit is tested before escape
		while (n < MAX_ITER) begin
			xx = x * x;
			yy = y * y;
			mag = $unsigned(xx) + $unsigned(yy);
			if (CAN_ESCAPE && mag > MAG_LIMIT) begin
				break;
			end
			xy = x * y;
			x = clip32(((xx - yy) >>> FRAC_BITS) + cx);
			y = clip32((xy >>> (FRAC_BITS - 1)) + cy);
			n++;
		end
		r.iter_count = 9'(n);
		r.shade      = 9'(MAX_ITER - n);
		r.inside_res = (n >= MAX_ITER);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] rand_coord();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return 16'h0000;
		end
		if (r == 1) begin
			return 16'hffff;
		end
		return 16'($urandom);
	endfunction

	task automatic send_point(input logic [15:0] u, input logic [15:0] v);
		int       gap;
		in_item_t pt;
		gap = pick_gap();
		pt.coord_u = u;
		pt.coord_v = v;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = pt;
		do @(posedge clk); while (!in_ready);
		expected_escapes.push_back(escape_time(pt));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_escapes.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_LEFT: begin
				win_left = $signed(val);
			end
			REG_RIGHT: begin
				win_right = $signed(val);
			end
			REG_BOTTOM: begin
				win_bottom = $signed(val);
			end
			default: begin
				win_top = $signed(val);
			end
		endcase
	endtask

	task automatic set_window(input logic [31:0] l, input logic [31:0] r,
			input logic [31:0] b, input logic [31:0] t);
		drain();
		write_reg(REG_LEFT, l);
		write_reg(REG_RIGHT, r);
		write_reg(REG_BOTTOM, b);
		write_reg(REG_TOP, t);
	endtask

	task automatic test_directed();
		// default window after reset
		send_point(16'h0000, 16'h0000);
		send_point(16'hffff, 16'hffff);
		send_point(16'h0000, 16'hffff);
		send_point(16'hffff, 16'h0000);
		send_point(16'h8000, 16'h8000);
		send_point(16'haaaa, 16'h8000);
		send_point(16'h5555, 16'h8000);
		// c = -2 exactly, magnitude sits on the threshold
		send_point(16'h0000, 16'h8000);
		// c = 0.25 exactly and just beyond the cusp
		send_point(16'hc000, 16'h8000);
		send_point(16'hc008, 16'h8000);
		// immediate escape
		set_window(32'sd805306368, 32'sd1073741823, 32'sd0, 32'sd0);
		send_point(16'h0000, 16'h0000);
		send_point(16'hffff, 16'hffff);
		// full signed range on both axes
		set_window(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_point(16'h0000, 16'h0000);
		send_point(16'hffff, 16'hffff);
		send_point(16'h8000, 16'h8000);
		// reversed window
		set_window(RST_RIGHT, RST_LEFT, RST_TOP, RST_BOTTOM);
		send_point(16'h0000, 16'h0000);
		send_point(16'hffff, 16'hffff);
		send_point(16'h5555, 16'h8000);
		// zero-size window at the origin
		set_window(32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_point(16'h1234, 16'hfedc);
		send_point(16'hffff, 16'h0000);
	endtask

	task automatic test_default_random(input int n);
		set_window(RST_LEFT, RST_RIGHT, RST_BOTTOM, RST_TOP);
		repeat (n) send_point(rand_coord(), rand_coord());
	endtask

	task automatic test_random_windows(input int windows, input int per_window);
		longint ctr_x, ctr_y, half_x, half_y;
		repeat (windows) begin
			ctr_x  = -536870912 + longint'($urandom_range(0, 805306368));
			ctr_y  = -402653184 + longint'($urandom_range(0, 805306368));
			half_x = longint'(1) << $urandom_range(12, 29);
			half_y = longint'(1) << $urandom_range(12, 29);
			if ($urandom_range(0, 5) == 0) begin
				half_x = -half_x;
			end
			if ($urandom_range(0, 5) == 0) begin
				half_y = -half_y;
			end
			set_window(32'(ctr_x - half_x), 32'(ctr_x + half_x),
				32'(ctr_y - half_y), 32'(ctr_y + half_y));
			repeat (per_window) send_point(rand_coord(), rand_coord());
		end
	endtask

	task automatic test_extreme_windows();
		set_window(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		repeat (20) send_point(rand_coord(), rand_coord());
		set_window(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
		repeat (20) send_point(rand_coord(), rand_coord());
		set_window(RST_LEFT, RST_RIGHT, 32'h80000000, 32'h7fffffff);
		repeat (20) send_point(rand_coord(), rand_coord());
		set_window(32'sd0, 32'sd0, 32'sd0, 32'sd0);
		repeat (5) send_point(rand_coord(), rand_coord());
	endtask

	task automatic test_reversed(input int n);
		set_window(RST_RIGHT, RST_LEFT, RST_TOP, RST_BOTTOM);
		repeat (n) send_point(rand_coord(), rand_coord());
	endtask

	task automatic test_no_idle(input int n);
		set_window(RST_LEFT, RST_RIGHT, RST_BOTTOM, RST_TOP);
		quiet = 1'b1;
		repeat (n) send_point(rand_coord(), rand_coord());
		drain();
		quiet = 1'b0;
	endtask

	task automatic test_pressure(input int n);
		drain();
		hold_off = 1'b1;
		repeat (n) send_point(rand_coord(), rand_coord());
		drain();
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int g;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off  = 1'b0;
				out_ready = 1'b1;
			end else begin
				g = pick_gap();
				if (g == 0) begin
					out_ready = 1'b1;
				end else begin
					out_ready = 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_escapes.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %0d/%0d/%0d",
					$time, out_data.iter_count, out_data.shade, out_data.inside_res);
				mismatches++;
			end else begin
				want = expected_escapes.pop_front();
				if (out_data.iter_count !== want.iter_count) begin
					$display("%0t: iter_count expected %0d actual %0d",
						$time, want.iter_count, out_data.iter_count);
					mismatches++;
				end
				if (out_data.shade !== want.shade) begin
					$display("%0t: shade expected %0d actual %0d",
						$time, want.shade, out_data.shade);
					mismatches++;
				end
				if (out_data.inside_res !== want.inside_res) begin
					$display("%0t: inside_res expected %0d actual %0d",
						$time, want.inside_res, out_data.inside_res);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin : run_tests
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_default_random(200);
		test_random_windows(12, 25);
		test_extreme_windows();
		test_reversed(100);
		test_no_idle(40);
		test_pressure(12);
		drain();
		repeat (600) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ mandelbrot_escape_time.f @@
rtl/mbe_pkg.sv
rtl/mbe_datapath.sv
rtl/mbe_ctrl.sv
rtl/mandelbrot_escape_time.sv
sim/tb_mandelbrot_escape_time.sv
